// ===== design/bank_access_balance_monitor_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bank access balance monitor
// Immediate-implication and next-cycle-implication checks, clocked on the
// rising edge and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef BANK_ACCESS_BALANCE_MONITOR_TOP_ASSERT_SVH
`define BANK_ACCESS_BALANCE_MONITOR_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define BABM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define BABM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/babm_pkg.sv =====
// ----------------------------------------------------------------------------
// babm_pkg
// Field widths, register indexes and reset values shared by the bank access
// balance monitor and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package babm_pkg;

   localparam int BANK_W  = 6;
   localparam int STAT_W  = 32;
   localparam int IDLE_W  = 7;
   localparam int GAP_W   = 32;
   localparam int LIMIT1_W = 8;
   localparam int LIMIT2_W = 8;
   localparam int LIMIT3_W = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [LIMIT1_W-1:0] LIMIT1_RESET = 8'd8;
   localparam logic [LIMIT2_W-1:0] LIMIT2_RESET = 8'd12;
   localparam logic [LIMIT3_W-1:0] LIMIT3_RESET = 10'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAP_LIMIT_FIRST  = 2'd0,
      CSR_GAP_LIMIT_SECOND = 2'd1,
      CSR_GAP_LIMIT_THIRD  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              queue_nonempty;
      logic              issue_valid;
      logic [BANK_W-1:0] bank;
      logic              bank_valid;
      logic              is_column;
      logic              is_activate;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0] access_total;
      logic [STAT_W-1:0] access_peak;
      logic [IDLE_W-1:0] idle_banks;
      logic [STAT_W-1:0] activate_total;
      logic [STAT_W-1:0] activate_peak;
      logic [STAT_W-1:0] nonempty_cycles;
      logic [STAT_W-1:0] stalled_cycles;
      logic [STAT_W-1:0] gap_sum;
      logic [STAT_W-1:0] gap_bin_first;
      logic [STAT_W-1:0] gap_bin_second;
      logic [STAT_W-1:0] gap_bin_third;
      logic [STAT_W-1:0] gap_bin_fourth;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== design/babm_if.sv =====
// ----------------------------------------------------------------------------
// babm_req_if / babm_rsp_if
// Valid/ready channels carrying command-bus observations in and statistics
// snapshots out.
// ----------------------------------------------------------------------------
`default_nettype none

interface babm_req_if;
   import babm_pkg::*;

   logic              valid;
   logic              ready;
   logic              queue_nonempty;
   logic              issue_valid;
   logic [BANK_W-1:0] bank;
   logic              bank_valid;
   logic              is_column;
   logic              is_activate;

   modport source (
      output valid, queue_nonempty, issue_valid, bank, bank_valid, is_column,
             is_activate,
      input  ready
   );

   modport sink (
      input  valid, queue_nonempty, issue_valid, bank, bank_valid, is_column,
             is_activate,
      output ready
   );
endinterface

interface babm_rsp_if;
   import babm_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] access_total;
   logic [STAT_W-1:0] access_peak;
   logic [IDLE_W-1:0] idle_banks;
   logic [STAT_W-1:0] activate_total;
   logic [STAT_W-1:0] activate_peak;
   logic [STAT_W-1:0] nonempty_cycles;
   logic [STAT_W-1:0] stalled_cycles;
   logic [STAT_W-1:0] gap_sum;
   logic [STAT_W-1:0] gap_bin_first;
   logic [STAT_W-1:0] gap_bin_second;
   logic [STAT_W-1:0] gap_bin_third;
   logic [STAT_W-1:0] gap_bin_fourth;

   modport source (
      output valid, access_total, access_peak, idle_banks, activate_total,
             activate_peak, nonempty_cycles, stalled_cycles, gap_sum,
             gap_bin_first, gap_bin_second, gap_bin_third, gap_bin_fourth,
      input  ready
   );

   modport sink (
      input  valid, access_total, access_peak, idle_banks, activate_total,
             activate_peak, nonempty_cycles, stalled_cycles, gap_sum,
             gap_bin_first, gap_bin_second, gap_bin_third, gap_bin_fourth,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/bank_access_balance_monitor_top.sv =====
// ----------------------------------------------------------------------------
// bank_access_balance_monitor_top
// Memory-controller bank utilisation monitor with saturating per-bank access
// and activate counters, cycle counters and a column-gap histogram.
// ----------------------------------------------------------------------------
// The monitor takes one item per clock unless the result side stalls, and
// returns one statistics snapshot per item. The item is registered together
// with the per-bank access and activate counts read from two counter memories;
// when the output register can take it, the counts are incremented, written
// back and folded into the totals, peaks, idle-bank count and gap histogram,
// and the snapshot lands in the output register. A write-back bypass lets
// consecutive items hit the same bank, so the unstalled rate is one item per
// cycle. Per-bank valid bits give the memories their zero reset without a
// clearing pass. Gap limits should be written only while no item is in flight.
`default_nettype none

module bank_access_balance_monitor_top #(
   parameter int NUM_BANKS   = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   babm_req_if.sink                               req_chan,
   babm_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_write_enable,
   input  wire logic [babm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [babm_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import babm_pkg::*;

   `include "bank_access_balance_monitor_top_assert.svh"

   localparam int ADDR_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int UNACC_W = $clog2(NUM_BANKS + 1);
   localparam int SUM_W = ((COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [UNACC_W-1:0] UNACC_RESET = UNACC_W'(NUM_BANKS);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

   // configuration
   logic [LIMIT1_W-1:0] limit1_ff;
   logic [LIMIT2_W-1:0] limit2_ff;
   logic [LIMIT3_W-1:0] limit3_ff;

   // handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, move;

   // stage one
   req_item_type     s1_item_ff;
   logic             s1_hit_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [ADDR_W-1:0] req_addr;
   logic             req_hit;

   // counter memories and bypass
   count_type acc_mem [NUM_BANKS];
   count_type act_mem [NUM_BANKS];
   count_type acc_rd_ff, act_rd_ff;
   logic [NUM_BANKS-1:0] acc_vld_ff, act_vld_ff;
   logic              fwd_acc_valid_ff, fwd_act_valid_ff;
   logic [ADDR_W-1:0] fwd_acc_addr_ff, fwd_act_addr_ff;
   count_type         fwd_acc_data_ff, fwd_act_data_ff;
   count_type acc_old, act_old, acc_new, act_new;
   logic      acc_wr, act_wr;

   // global statistics
   count_type access_sum_ff, access_sum_in;
   count_type access_max_ff, access_max_in;
   logic [UNACC_W-1:0] unacc_ff, unacc_in;
   count_type activate_sum_ff, activate_sum_in;
   count_type activate_max_ff, activate_max_in;
   count_type busy_ff, busy_in;
   count_type stall_ff, stall_in;
   count_type gap_total_ff, gap_total_in;
   count_type gap_bins_ff [4];
   count_type gap_bins_in [4];
   logic [GAP_W-1:0] cycle_ff, cycle_in;
   logic [GAP_W-1:0] last_col_ff, last_col_in;
   logic             has_last_ff, has_last_in;

   logic [GAP_W-1:0] gap;
   logic [SUM_W-1:0] gap_sum_wide;
   logic [1:0]       gap_bin;

   rsp_item_type rsp_ff, rsp_in;

   // handshake ---------------------------------------------------------------
   assign move = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || move;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_addr = ADDR_W'(req_chan.bank);
   assign req_hit = req_chan.issue_valid && req_chan.bank_valid &&
                    (int'(req_chan.bank) < NUM_BANKS);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         limit1_ff <= LIMIT1_RESET;
         limit2_ff <= LIMIT2_RESET;
         limit3_ff <= LIMIT3_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_GAP_LIMIT_FIRST: begin
               limit1_ff <= csr_write_data[LIMIT1_W-1:0];
            end
            CSR_GAP_LIMIT_SECOND: begin
               limit2_ff <= csr_write_data[LIMIT2_W-1:0];
            end
            CSR_GAP_LIMIT_THIRD: begin
               limit3_ff <= csr_write_data[LIMIT3_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage one payload and counter reads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{queue_nonempty: req_chan.queue_nonempty,
                         issue_valid:    req_chan.issue_valid,
                         bank:           req_chan.bank,
                         bank_valid:     req_chan.bank_valid,
                         is_column:      req_chan.is_column,
                         is_activate:    req_chan.is_activate};
         s1_hit_ff  <= req_hit;
         s1_addr_ff <= req_addr;
         acc_rd_ff  <= acc_mem[req_addr];
         act_rd_ff  <= act_mem[req_addr];
      end
      if (acc_wr) begin
         acc_mem[s1_addr_ff] <= acc_new;
      end
      if (act_wr) begin
         act_mem[s1_addr_ff] <= act_new;
      end
   end

   // stage two: counter update ------------------------------------------------
   always_comb begin
      // take the last write-back when the read raced it
      if (fwd_acc_valid_ff && fwd_acc_addr_ff == s1_addr_ff) begin
         acc_old = fwd_acc_data_ff;
      end else if (acc_vld_ff[s1_addr_ff]) begin
         acc_old = acc_rd_ff;
      end else begin
         acc_old = '0;
      end
      if (fwd_act_valid_ff && fwd_act_addr_ff == s1_addr_ff) begin
         act_old = fwd_act_data_ff;
      end else if (act_vld_ff[s1_addr_ff]) begin
         act_old = act_rd_ff;
      end else begin
         act_old = '0;
      end
   end

   assign acc_new = sat_inc(acc_old);
   assign act_new = sat_inc(act_old);
   assign acc_wr = move && s1_hit_ff && s1_item_ff.is_column;
   assign act_wr = move && s1_hit_ff && s1_item_ff.is_activate;

   assign gap = cycle_ff - last_col_ff;
   assign gap_sum_wide = SUM_W'(gap_total_ff) + SUM_W'(gap);

   always_comb begin
      if (gap <= GAP_W'(limit1_ff)) begin
         gap_bin = 2'd0;
      end else if (gap <= GAP_W'(limit2_ff)) begin
         gap_bin = 2'd1;
      end else if (gap <= GAP_W'(limit3_ff)) begin
         gap_bin = 2'd2;
      end else begin
         gap_bin = 2'd3;
      end
   end

   always_comb begin
      access_sum_in   = access_sum_ff;
      access_max_in   = access_max_ff;
      unacc_in        = unacc_ff;
      activate_sum_in = activate_sum_ff;
      activate_max_in = activate_max_ff;
      busy_in         = busy_ff;
      stall_in        = stall_ff;
      gap_total_in    = gap_total_ff;
      gap_bins_in     = gap_bins_ff;
      cycle_in        = cycle_ff;
      last_col_in     = last_col_ff;
      has_last_in     = has_last_ff;
      if (move) begin
         cycle_in = cycle_ff + GAP_W'(1);
         if (s1_item_ff.queue_nonempty) begin
            busy_in = sat_inc(busy_ff);
            if (!s1_item_ff.issue_valid) begin
               stall_in = sat_inc(stall_ff);
            end
         end
         if (acc_wr) begin
            if (acc_old == '0 && unacc_ff != '0) begin
               unacc_in = unacc_ff - UNACC_W'(1);
            end
            access_sum_in = sat_inc(access_sum_ff);
            if (acc_new > access_max_ff) begin
               access_max_in = acc_new;
            end
            if (has_last_ff) begin
               gap_total_in = (gap_sum_wide > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                                : COUNT_WIDTH'(gap_sum_wide);
               gap_bins_in[gap_bin] = sat_inc(gap_bins_ff[gap_bin]);
            end
            last_col_in = cycle_ff;
            has_last_in = 1'b1;
         end
         if (act_wr) begin
            activate_sum_in = sat_inc(activate_sum_ff);
            if (act_new > activate_max_ff) begin
               activate_max_in = act_new;
            end
         end
      end
   end

   always_comb begin
      rsp_in.access_total    = STAT_W'(access_sum_in);
      rsp_in.access_peak     = STAT_W'(access_max_in);
      rsp_in.idle_banks      = IDLE_W'(unacc_in);
      rsp_in.activate_total  = STAT_W'(activate_sum_in);
      rsp_in.activate_peak   = STAT_W'(activate_max_in);
      rsp_in.nonempty_cycles = STAT_W'(busy_in);
      rsp_in.stalled_cycles  = STAT_W'(stall_in);
      rsp_in.gap_sum         = STAT_W'(gap_total_in);
      rsp_in.gap_bin_first   = STAT_W'(gap_bins_in[0]);
      rsp_in.gap_bin_second  = STAT_W'(gap_bins_in[1]);
      rsp_in.gap_bin_third   = STAT_W'(gap_bins_in[2]);
      rsp_in.gap_bin_fourth  = STAT_W'(gap_bins_in[3]);
   end

   // state registers ----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         acc_vld_ff       <= '0;
         act_vld_ff       <= '0;
         fwd_acc_valid_ff <= 1'b0;
         fwd_act_valid_ff <= 1'b0;
         access_sum_ff    <= '0;
         access_max_ff    <= '0;
         unacc_ff         <= UNACC_RESET;
         activate_sum_ff  <= '0;
         activate_max_ff  <= '0;
         busy_ff          <= '0;
         stall_ff         <= '0;
         gap_total_ff     <= '0;
         gap_bins_ff      <= '{default: '0};
         cycle_ff         <= '0;
         last_col_ff      <= '0;
         has_last_ff      <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         access_sum_ff   <= access_sum_in;
         access_max_ff   <= access_max_in;
         unacc_ff        <= unacc_in;
         activate_sum_ff <= activate_sum_in;
         activate_max_ff <= activate_max_in;
         busy_ff         <= busy_in;
         stall_ff        <= stall_in;
         gap_total_ff    <= gap_total_in;
         gap_bins_ff     <= gap_bins_in;
         cycle_ff        <= cycle_in;
         last_col_ff     <= last_col_in;
         has_last_ff     <= has_last_in;
         if (acc_wr) begin
            acc_vld_ff[s1_addr_ff] <= 1'b1;
            fwd_acc_valid_ff       <= 1'b1;
         end
         if (act_wr) begin
            act_vld_ff[s1_addr_ff] <= 1'b1;
            fwd_act_valid_ff       <= 1'b1;
         end
      end
   end

   // bypass payload and result register
   always_ff @(posedge clock) begin
      if (acc_wr) begin
         fwd_acc_addr_ff <= s1_addr_ff;
         fwd_acc_data_ff <= acc_new;
      end
      if (act_wr) begin
         fwd_act_addr_ff <= s1_addr_ff;
         fwd_act_data_ff <= act_new;
      end
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.access_total    = rsp_ff.access_total;
   assign rsp_chan.access_peak     = rsp_ff.access_peak;
   assign rsp_chan.idle_banks      = rsp_ff.idle_banks;
   assign rsp_chan.activate_total  = rsp_ff.activate_total;
   assign rsp_chan.activate_peak   = rsp_ff.activate_peak;
   assign rsp_chan.nonempty_cycles = rsp_ff.nonempty_cycles;
   assign rsp_chan.stalled_cycles  = rsp_ff.stalled_cycles;
   assign rsp_chan.gap_sum         = rsp_ff.gap_sum;
   assign rsp_chan.gap_bin_first   = rsp_ff.gap_bin_first;
   assign rsp_chan.gap_bin_second  = rsp_ff.gap_bin_second;
   assign rsp_chan.gap_bin_third   = rsp_ff.gap_bin_third;
   assign rsp_chan.gap_bin_fourth  = rsp_ff.gap_bin_fourth;

   // assertions ---------------------------------------------------------------
   `BABM_ASSERT_NEXT(a_move_fills_rsp, clock, reset, move, rsp_chan.valid,
                     "item lost on its way to the output")
   `BABM_ASSERT_NOW(a_full_blocks_req, clock, reset,
                    s1_valid_ff && rsp_chan.valid && !rsp_chan.ready, !req_chan.ready,
                    "item taken while both stages are held")
   `BABM_ASSERT_NOW(a_access_sum_peak, clock, reset, 1'b1, access_sum_ff >= access_max_ff,
                    "access peak above access total")
   `BABM_ASSERT_NOW(a_activate_sum_peak, clock, reset, 1'b1,
                    activate_sum_ff >= activate_max_ff, "activate peak above activate total")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Bank access balance monitor testbench
// Sends command-bus observations through the request channel and checks
// every statistics snapshot against a cycle-free model of the counters that
// runs alongside. Stimulus opens with a short directed sequence, then runs
// random phases under several gap-limit settings, with bursty sending and
// patterned stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
   import babm_pkg::*;

   localparam int NUM_BANKS     = 64;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   // Running copy of the monitor's counters; one snapshot per accepted item.
   class bank_stats_scoreboard;
      bit [LIMIT1_W-1:0] limit_first;
      bit [LIMIT2_W-1:0] limit_second;
      bit [LIMIT3_W-1:0] limit_third;
      bit [STAT_W-1:0]   access_count [NUM_BANKS];
      bit [STAT_W-1:0]   activate_count [NUM_BANKS];
      bit [STAT_W-1:0]   access_sum;
      bit [STAT_W-1:0]   access_max;
      bit [IDLE_W-1:0]   unaccessed;
      bit [STAT_W-1:0]   activate_sum;
      bit [STAT_W-1:0]   activate_max;
      bit [STAT_W-1:0]   busy;
      bit [STAT_W-1:0]   stalled;
      bit [STAT_W-1:0]   gap_total;
      bit [STAT_W-1:0]   gap_bin [4];
      bit [STAT_W-1:0]   stamp;
      bit [STAT_W-1:0]   last_column;
      bit                has_last_column;
      rsp_item_type      snapshot_q[$];
      int                failures;

      function new();
         limit_first  = LIMIT1_RESET;
         limit_second = LIMIT2_RESET;
         limit_third  = LIMIT3_RESET;
         unaccessed   = IDLE_W'(NUM_BANKS);
         failures     = 0;
      endfunction

      function bit [STAT_W-1:0] sat_inc(bit [STAT_W-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function bit [STAT_W-1:0] sat_add(bit [STAT_W-1:0] v, bit [STAT_W-1:0] d);
         bit [STAT_W:0] total;
         total = {1'b0, v} + {1'b0, d};
         return total[STAT_W] ? '1 : total[STAT_W-1:0];
      endfunction

      function void set_limit(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_GAP_LIMIT_FIRST:  limit_first  = value[LIMIT1_W-1:0];
            CSR_GAP_LIMIT_SECOND: limit_second = value[LIMIT2_W-1:0];
            CSR_GAP_LIMIT_THIRD:  limit_third  = value[LIMIT3_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_command(req_item_type cmd);
         rsp_item_type    snap;
         bit [STAT_W-1:0] gap;
         bit [STAT_W-1:0] count;
         int unsigned     slot;
         if (cmd.queue_nonempty) begin
            busy = sat_inc(busy);
            if (!cmd.issue_valid)
               stalled = sat_inc(stalled);
         end
         if (cmd.issue_valid && cmd.bank_valid && cmd.bank < NUM_BANKS) begin
            if (cmd.is_column) begin
               count = access_count[cmd.bank];
               if (count == 0 && unaccessed != 0)
                  unaccessed--;
               count = sat_inc(count);
               access_count[cmd.bank] = count;
               access_sum = sat_inc(access_sum);
               if (count > access_max)
                  access_max = count;
               if (has_last_column) begin
                  gap = stamp - last_column;
                  gap_total = sat_add(gap_total, gap);
                  if (gap <= limit_first)
                     slot = 0;
                  else if (gap <= limit_second)
                     slot = 1;
                  else if (gap <= limit_third)
                     slot = 2;
                  else
                     slot = 3;
                  gap_bin[slot] = sat_inc(gap_bin[slot]);
               end
               last_column = stamp;
               has_last_column = 1'b1;
            end
            if (cmd.is_activate) begin
               count = sat_inc(activate_count[cmd.bank]);
               activate_count[cmd.bank] = count;
               activate_sum = sat_inc(activate_sum);
               if (count > activate_max)
                  activate_max = count;
            end
         end
         stamp = stamp + 1'b1;

         snap.access_total    = access_sum;
         snap.access_peak     = access_max;
         snap.idle_banks      = unaccessed;
         snap.activate_total  = activate_sum;
         snap.activate_peak   = activate_max;
         snap.nonempty_cycles = busy;
         snap.stalled_cycles  = stalled;
         snap.gap_sum         = gap_total;
         snap.gap_bin_first   = gap_bin[0];
         snap.gap_bin_second  = gap_bin[1];
         snap.gap_bin_third   = gap_bin[2];
         snap.gap_bin_fourth  = gap_bin[3];
         snapshot_q.push_back(snap);
      endfunction

      function void compare_field(string name, logic [STAT_W-1:0] want,
                                  logic [STAT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_snapshot(rsp_item_type got);
         rsp_item_type want;
         if (snapshot_q.size() == 0) begin
            $error("snapshot arrived with no item outstanding");
            failures++;
            return;
         end
         want = snapshot_q.pop_front();
         compare_field("access_total", want.access_total, got.access_total);
         compare_field("access_peak", want.access_peak, got.access_peak);
         compare_field("idle_banks", STAT_W'(want.idle_banks), STAT_W'(got.idle_banks));
         compare_field("activate_total", want.activate_total, got.activate_total);
         compare_field("activate_peak", want.activate_peak, got.activate_peak);
         compare_field("nonempty_cycles", want.nonempty_cycles, got.nonempty_cycles);
         compare_field("stalled_cycles", want.stalled_cycles, got.stalled_cycles);
         compare_field("gap_sum", want.gap_sum, got.gap_sum);
         compare_field("gap_bin_first", want.gap_bin_first, got.gap_bin_first);
         compare_field("gap_bin_second", want.gap_bin_second, got.gap_bin_second);
         compare_field("gap_bin_third", want.gap_bin_third, got.gap_bin_third);
         compare_field("gap_bin_fourth", want.gap_bin_fourth, got.gap_bin_fourth);
      endfunction

      function int pending();
         return snapshot_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   babm_req_if req_bus ();
   babm_rsp_if rsp_bus ();

   bank_stats_scoreboard board;
   int                   cycles = 0;
   int                   burst_left = 0;

   bank_access_balance_monitor_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: stall in stretches, each with a pattern of its own.
   initial begin : receiver
      int             stretch_left;
      stall_mode_type mode;
      stretch_left = 0;
      mode = STALL_NONE;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(8, 120);
         end
         stretch_left--;
         case (mode)
            STALL_NONE:  rsp_bus.ready <= 1'b1;
            STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_bus.ready <= ~rsp_bus.ready;
         endcase
      end
   end

   always @(posedge clock) begin : snapshot_monitor
      rsp_item_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.access_total    = rsp_bus.access_total;
         got.access_peak     = rsp_bus.access_peak;
         got.idle_banks      = rsp_bus.idle_banks;
         got.activate_total  = rsp_bus.activate_total;
         got.activate_peak   = rsp_bus.activate_peak;
         got.nonempty_cycles = rsp_bus.nonempty_cycles;
         got.stalled_cycles  = rsp_bus.stalled_cycles;
         got.gap_sum         = rsp_bus.gap_sum;
         got.gap_bin_first   = rsp_bus.gap_bin_first;
         got.gap_bin_second  = rsp_bus.gap_bin_second;
         got.gap_bin_third   = rsp_bus.gap_bin_third;
         got.gap_bin_fourth  = rsp_bus.gap_bin_fourth;
         board.check_snapshot(got);
      end
   end

   function automatic req_item_type make_cmd(int unsigned queued, int unsigned issued,
                                             int unsigned bank, int unsigned bank_ok,
                                             int unsigned column, int unsigned activate);
      req_item_type cmd;
      cmd.queue_nonempty = queued[0];
      cmd.issue_valid    = issued[0];
      cmd.bank           = BANK_W'(bank);
      cmd.bank_valid     = bank_ok[0];
      cmd.is_column      = column[0];
      cmd.is_activate    = activate[0];
      return cmd;
   endfunction

   // Distance to the next column command, mostly short to land near the limits.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return $urandom_range(0, 14);
      if (roll < 8)
         return $urandom_range(0, 40);
      return $urandom_range(0, 300);
   endfunction

   // Burst pacing: between most bursts, drop valid before sending on.
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_command(req_item_type cmd);
      pace();
      req_bus.valid          <= 1'b1;
      req_bus.queue_nonempty <= cmd.queue_nonempty;
      req_bus.issue_valid    <= cmd.issue_valid;
      req_bus.bank           <= cmd.bank;
      req_bus.bank_valid     <= cmd.bank_valid;
      req_bus.is_column      <= cmd.is_column;
      req_bus.is_activate    <= cmd.is_activate;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      board.note_command(cmd);
   endtask

   // Hold the sender until every snapshot is back, then let the pipe settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      board.set_limit(index, value);
   endtask

   task automatic program_limits(int unsigned first_limit,
                                 int unsigned second_limit,
                                 int unsigned third_limit);
      wait_idle();
      write_csr(CSR_GAP_LIMIT_FIRST, CSR_DATA_W'(first_limit));
      write_csr(CSR_GAP_LIMIT_SECOND, CSR_DATA_W'(second_limit));
      write_csr(CSR_GAP_LIMIT_THIRD, CSR_DATA_W'(third_limit));
      // an unmapped index must leave every limit alone
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom_range(0, 1023)));
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_directed();
      int unsigned n;
      send_command(make_cmd(1, 0, 0, 0, 0, 0));
      send_command(make_cmd(0, 0, 63, 1, 1, 1));
      send_command(make_cmd(1, 1, 0, 1, 1, 0));
      send_command(make_cmd(0, 1, 63, 1, 1, 1));
      send_command(make_cmd(1, 1, 42, 0, 1, 1));
      send_command(make_cmd(1, 1, 63, 1, 0, 1));
      send_command(make_cmd(1, 1, 0, 1, 1, 1));
      for (n = 0; n < 9; n++)
         send_command(make_cmd(1, 0, 21, 1, 1, 1));
      send_command(make_cmd(1, 1, 63, 1, 1, 0));
      send_command(make_cmd(0, 1, 21, 1, 0, 0));
      send_command(make_cmd(1, 1, 0, 0, 0, 0));
   endtask

   // Column commands follow a gap schedule; everything else is random noise.
   task automatic run_random(int unsigned count, int unsigned long_gap);
      req_item_type cmd;
      int unsigned  n;
      int unsigned  quiet_left;
      bit           counted;
      bit           forced;
      quiet_left = $urandom_range(0, 4);
      forced = (long_gap != 0);
      for (n = 0; n < count; n++) begin
         cmd.queue_nonempty = ($urandom_range(0, 3) != 0);
         cmd.issue_valid    = ($urandom_range(0, 3) != 0);
         cmd.bank           = ($urandom_range(0, 1) != 0) ? BANK_W'($urandom_range(0, 3))
                                                          : BANK_W'($urandom_range(0, 63));
         cmd.bank_valid     = ($urandom_range(0, 15) != 0);
         cmd.is_activate    = ($urandom_range(0, 2) == 0);
         counted = cmd.issue_valid && cmd.bank_valid;
         if (!counted) begin
            cmd.is_column = 1'($urandom_range(0, 1));
         end else if (quiet_left == 0) begin
            cmd.is_column = 1'b1;
            if (forced) begin
               quiet_left = long_gap;
               forced = 1'b0;
            end else begin
               quiet_left = pick_gap();
            end
         end else begin
            cmd.is_column = (quiet_left < 200) && ($urandom_range(0, 49) == 0);
         end
         if (quiet_left != 0)
            quiet_left--;
         send_command(cmd);
      end
   endtask

   initial begin : stimulus
      board = new();
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_GAP_LIMIT_FIRST;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.queue_nonempty = 1'b0;
      req_bus.issue_valid = 1'b0;
      req_bus.bank = '0;
      req_bus.bank_valid = 1'b0;
      req_bus.is_column = 1'b0;
      req_bus.is_activate = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(100, 0);
      program_limits(1, 1, 1);
      run_random(60, 0);
      program_limits(255, 255, 1023);
      run_random(1040, 1030);
      program_limits(200, 5, 3);
      run_random(40, 0);
      program_limits($urandom_range(1, 255), $urandom_range(1, 255),
                     $urandom_range(1, 1023));
      run_random(45, 0);
      program_limits($urandom_range(1, 20), $urandom_range(10, 40),
                     $urandom_range(20, 120));
      run_random(45, 0);
      wait_idle();

      if (board.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== bank_access_balance_monitor_top.f =====
+incdir+design
design/babm_pkg.sv
design/babm_if.sv
design/bank_access_balance_monitor_top.sv
bench/testbench.sv
